// ===== rtl/rgb_to_nv12_converter_defines.svh =====
// Assertion macros shared by the RGB to NV12 converter RTL.
`ifndef RGB_TO_NV12_CONVERTER_DEFINES_SVH
`define RGB_TO_NV12_CONVERTER_DEFINES_SVH

`ifndef SYNTH

// Checked property, disabled while reset is high.
`define R2N_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("r2n assertion failed");

// Checked property that also holds during reset.
`define R2N_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("r2n assertion failed");

`else

`define R2N_ASSERT(label, clk, rst, prop)

`define R2N_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

// ===== rtl/r2n_pkg.sv =====
// Constants, types and arithmetic functions of the RGB to NV12 converter.
package r2n_pkg;

   localparam int MaxWidth      = 4096;
   localparam int MaxHeight     = 4096;
   localparam int LineDepth     = (MaxWidth + 1) / 2;
   localparam int LineAddrWidth = $clog2(LineDepth);
   localparam int CoordWidth    = 12;
   localparam int CfgWidth      = 13;
   localparam int SumWidth      = 10;
   localparam int LineWidth     = 3 * SumWidth;
   localparam int CsrAddrWidth  = 3;
   localparam int CsrDataWidth  = 32;
   localparam int ResCount      = 5;

   localparam logic [CfgWidth-1:0] WidthReset  = CfgWidth'(1);
   localparam logic [CfgWidth-1:0] HeightReset = CfgWidth'(1);

   // Register index, taken from address bit 2.
   localparam logic RegSrcWidth  = 1'b0;
   localparam logic RegSrcHeight = 1'b1;

   localparam logic PlaneLuma   = 1'b0;
   localparam logic PlaneChroma = 1'b1;

   typedef logic [ResCount-1:0] res_mask_type;

   // One bit per result a pixel can cause, in emission order.
   localparam res_mask_type MaskOwn    = 5'b00001;
   localparam res_mask_type MaskPadCol = 5'b00010;
   localparam res_mask_type MaskPadRow = 5'b00100;
   localparam res_mask_type MaskCorner = 5'b01000;
   localparam res_mask_type MaskChroma = 5'b10000;

   typedef logic [CoordWidth-1:0] coord_type;
   typedef logic [7:0]            pixel_byte_type;
   typedef logic [8:0]            pair_sum_type;

   // Pixel after position decode and pair summing.
   typedef struct packed {
      coord_type      x;
      coord_type      y;
      pixel_byte_type red;
      pixel_byte_type green;
      pixel_byte_type blue;
      pair_sum_type   pair_r;
      pair_sum_type   pair_g;
      pair_sum_type   pair_b;
      logic           odd_row;
      res_mask_type   mask;
      logic           frame_done;
   } s1_type;

   // Pixel with luma and block averages ready for emission.
   typedef struct packed {
      coord_type      x;
      coord_type      y;
      pixel_byte_type luma;
      pixel_byte_type avg_r;
      pixel_byte_type avg_g;
      pixel_byte_type avg_b;
      res_mask_type   mask;
      logic           frame_done;
   } s2_type;

   function automatic pixel_byte_type clamp_byte(input logic signed [17:0] v);
      pixel_byte_type res;
      if (v < 18'sd0) begin
         res = 8'd0;
      end else if (v > 18'sd255) begin
         res = 8'd255;
      end else begin
         res = v[7:0];
      end
      return res;
   endfunction

   function automatic pixel_byte_type luma_of(input pixel_byte_type r,
                                              input pixel_byte_type g,
                                              input pixel_byte_type b);
      logic [15:0] acc;
      logic [8:0]  v;
      acc = 16'd47 * {8'd0, r} + 16'd157 * {8'd0, g} + {4'd0, b, 4'd0} + 16'd128;
      v   = {1'b0, acc[15:8]} + 9'd16;
      return (v > 9'd255) ? 8'd255 : v[7:0];
   endfunction

   function automatic pixel_byte_type avg_of(input logic [SumWidth-1:0] sum);
      logic [SumWidth:0] t;
      t = {1'b0, sum} + (SumWidth+1)'(2);
      return t[9:2];
   endfunction

   function automatic pixel_byte_type cb_of(input pixel_byte_type ar,
                                            input pixel_byte_type ag,
                                            input pixel_byte_type ab);
      logic signed [17:0] t;
      logic signed [17:0] s;
      t = 18'sd112 * $signed({10'd0, ab}) - 18'sd26 * $signed({10'd0, ar})
          - 18'sd87 * $signed({10'd0, ag}) + 18'sd128;
      s = (t >>> 8) + 18'sd128;
      return clamp_byte(s);
   endfunction

   function automatic pixel_byte_type cr_of(input pixel_byte_type ar,
                                            input pixel_byte_type ag,
                                            input pixel_byte_type ab);
      logic signed [17:0] t;
      logic signed [17:0] s;
      t = 18'sd112 * $signed({10'd0, ar}) - 18'sd102 * $signed({10'd0, ag})
          - 18'sd10 * $signed({10'd0, ab}) + 18'sd128;
      s = (t >>> 8) + 18'sd128;
      return clamp_byte(s);
   endfunction

endpackage

// ===== rtl/r2n_if.sv =====
// Valid/ready channel interfaces for source pixels and NV12 results.
interface r2n_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;

   modport source (output valid, red, green, blue, input ready);
   modport sink   (input valid, red, green, blue, output ready);
endinterface

interface r2n_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           plane;
   logic [r2n_pkg::CoordWidth-1:0] out_row;
   logic [r2n_pkg::CoordWidth-1:0] out_col;
   logic [7:0]                     luma_or_cb;
   logic [7:0]                     cr_value;
   logic                           last;
   logic                           frame_end;

   modport source (output valid, plane, out_row, out_col, luma_or_cb, cr_value, last,
                   frame_end, input ready);
   modport sink   (input valid, plane, out_row, out_col, luma_or_cb, cr_value, last,
                   frame_end, output ready);
endinterface

// ===== rtl/r2n_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module r2n_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(Depth)-1:0] waddr,
   input  logic [Width-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(Depth)-1:0] raddr,
   output logic [Width-1:0]         rdata
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/rgb_to_nv12_converter.sv =====
// Top level of the RGB to BT.709 limited-range NV12 stream converter.
//
//   Channel   Direction   Transfer when            Carries
//   req       in          req.valid & req.ready    red, green, blue of one source pixel
//   rsp       out         rsp.valid & rsp.ready    one luma byte or one Cb/Cr pair
//   csr_*     in/out      psel & penable & pwrite  src_width (0x0), src_height (0x4)
//
// A pixel passes stage 1, stage 2 and the result register before its first result is valid
// on rsp. The result register passes one result per cycle while rsp.ready holds, so a
// pixel occupies the emitter until all of the results it causes (one to five) have
// moved out; a pixel with one result sustains one per cycle while rsp.ready holds.
// The line store is read and written only at the input transfer, at most one access
// per pixel. Reset is synchronous and active high and needs no clearing pass; the
// line store is always written on an even row before the odd row reads it. A stall
// on rsp fills the pipeline and then drops req.ready.
module rgb_to_nv12_converter (
   input  logic                             clock,
   input  logic                             reset,
   r2n_req_if.sink                          req,
   r2n_rsp_if.source                        rsp,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [r2n_pkg::CsrAddrWidth-1:0] csr_paddr,
   input  logic [r2n_pkg::CsrDataWidth-1:0] csr_pwdata,
   output logic [r2n_pkg::CsrDataWidth-1:0] csr_prdata,
   output logic                             csr_pready
);
   import r2n_pkg::*;

`include "rgb_to_nv12_converter_defines.svh"

   // ---------------------------------------------------------------------------------
   // Configuration registers. They keep the raw value written; the clamp to the legal
   // range is applied where the frame position is decoded.
   // ---------------------------------------------------------------------------------
   logic                csr_wr;
   logic [CfgWidth-1:0] width_ff, width_in;
   logic [CfgWidth-1:0] height_ff, height_in;
   logic [CfgWidth-1:0] eff_w, eff_h;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_prdata = (csr_paddr[2] == RegSrcHeight)
                       ? CsrDataWidth'(height_ff) : CsrDataWidth'(width_ff);

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_wr && csr_paddr[2] == RegSrcWidth) begin
         width_in = csr_pwdata[CfgWidth-1:0];
      end
      if (csr_wr && csr_paddr[2] == RegSrcHeight) begin
         height_in = csr_pwdata[CfgWidth-1:0];
      end
   end

   // A zero size acts as one, and a size above the maximum acts as the maximum.
   always_comb begin
      if (width_ff == '0) begin
         eff_w = CfgWidth'(1);
      end else if (32'(width_ff) > 32'(MaxWidth)) begin
         eff_w = CfgWidth'(MaxWidth);
      end else begin
         eff_w = width_ff;
      end
      if (height_ff == '0) begin
         eff_h = CfgWidth'(1);
      end else if (32'(height_ff) > 32'(MaxHeight)) begin
         eff_h = CfgWidth'(MaxHeight);
      end else begin
         eff_h = height_ff;
      end
   end

   // ---------------------------------------------------------------------------------
   // Pipeline control. Stage 1 holds the decoded pixel while the line store read is
   // in flight, stage 2 holds the pixel and its pending results, and the result
   // register drives rsp. Stage 2 releases a pixel when its last result moves out.
   // ---------------------------------------------------------------------------------
   logic         req_acc;
   logic         s1_v_ff, s1_v_in;
   logic         s2_v_ff, s2_v_in;
   logic         rsp_v_ff, rsp_v_in;
   s1_type       s1_ff, s1_in;
   s2_type       s2_ff, s2_in;
   res_mask_type sel, rem;
   logic         single;
   logic         take;
   logic         s2_free;
   logic         s1_move;

   assign sel     = s2_ff.mask & (~s2_ff.mask + ResCount'(1));
   assign rem     = s2_ff.mask & ~sel;
   assign single  = (rem == '0);
   assign take    = s2_v_ff & (~rsp_v_ff | rsp.ready);
   assign s2_free = ~s2_v_ff | (take & single);
   assign s1_move = s1_v_ff & s2_free;

   assign req.ready = ~s1_v_ff | s2_free;
   assign req_acc   = req.valid & req.ready;

   // ---------------------------------------------------------------------------------
   // Input stage: frame position, padding flags, pair sums and the line store access.
   // ---------------------------------------------------------------------------------
   coord_type             column_count_ff, column_count_in;
   coord_type             row_count_ff, row_count_in;
   logic [23:0]           hold_ff, hold_in;
   coord_type             x_cur, y_cur;
   logic [CfgWidth-1:0]   x_next, y_next;
   logic                  wrap_x, frame_done;
   logic                  pad_col, pad_row;
   logic                  pair_done;
   pair_sum_type          pair_r, pair_g, pair_b;
   logic                  ram_we, ram_re;
   logic [LineAddrWidth-1:0] ram_addr;
   logic [LineWidth-1:0]  ram_wdata, ram_rdata;

   assign x_cur = ({1'b0, column_count_ff} >= eff_w) ? '0 : column_count_ff;
   assign y_cur = ({1'b0, row_count_ff} >= eff_h) ? '0 : row_count_ff;

   // The last column or row is repeated only when that size is odd.
   assign pad_col = ({1'b0, x_cur} == eff_w - CfgWidth'(1)) & eff_w[0];
   assign pad_row = ({1'b0, y_cur} == eff_h - CfgWidth'(1)) & eff_h[0];

   assign x_next     = {1'b0, x_cur} + CfgWidth'(1);
   assign y_next     = {1'b0, y_cur} + CfgWidth'(1);
   assign wrap_x     = (x_next >= eff_w);
   assign frame_done = wrap_x & (y_next >= eff_h);

   always_comb begin
      column_count_in = column_count_ff;
      row_count_in    = row_count_ff;
      if (csr_wr) begin
         column_count_in = '0;
         row_count_in    = '0;
      end else if (req_acc) begin
         column_count_in = wrap_x ? '0 : x_next[CoordWidth-1:0];
         if (wrap_x) begin
            row_count_in = frame_done ? '0 : y_next[CoordWidth-1:0];
         end else begin
            row_count_in = y_cur;
         end
      end
   end

   // An odd column adds the held even-column pixel; an even column pairs with itself,
   // which is what a padded last column needs.
   always_comb begin
      if (x_cur[0]) begin
         pair_r = {1'b0, req.red}   + {1'b0, hold_ff[7:0]};
         pair_g = {1'b0, req.green} + {1'b0, hold_ff[15:8]};
         pair_b = {1'b0, req.blue}  + {1'b0, hold_ff[23:16]};
      end else begin
         pair_r = {req.red, 1'b0};
         pair_g = {req.green, 1'b0};
         pair_b = {req.blue, 1'b0};
      end
      hold_in = hold_ff;
      if (req_acc && !x_cur[0]) begin
         hold_in = {req.blue, req.green, req.red};
      end
   end

   // Even rows store the pair sums, odd rows fetch them back for the 2x2 block.
   assign pair_done = x_cur[0] | pad_col;
   assign ram_we    = req_acc & pair_done & ~y_cur[0];
   assign ram_re    = req_acc & pair_done & y_cur[0];
   assign ram_addr  = LineAddrWidth'(x_cur >> 1);
   assign ram_wdata = {SumWidth'(pair_b), SumWidth'(pair_g), SumWidth'(pair_r)};

   r2n_ram #(
      .Width (LineWidth),
      .Depth (LineDepth)
   ) u_line_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_addr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_addr),
      .rdata (ram_rdata)
   );

   always_comb begin
      s1_in            = s1_ff;
      if (req_acc) begin
         s1_in.x          = x_cur;
         s1_in.y          = y_cur;
         s1_in.red        = req.red;
         s1_in.green      = req.green;
         s1_in.blue       = req.blue;
         s1_in.pair_r     = pair_r;
         s1_in.pair_g     = pair_g;
         s1_in.pair_b     = pair_b;
         s1_in.odd_row    = y_cur[0];
         s1_in.mask       = MaskOwn
                            | (pad_col ? MaskPadCol : '0)
                            | (pad_row ? MaskPadRow : '0)
                            | ((pad_col & pad_row) ? MaskCorner : '0)
                            | ((pair_done & (y_cur[0] | pad_row)) ? MaskChroma : '0);
         s1_in.frame_done = frame_done;
      end
      if (req_acc) begin
         s1_v_in = 1'b1;
      end else if (s1_move) begin
         s1_v_in = 1'b0;
      end else begin
         s1_v_in = s1_v_ff;
      end
   end

   // ---------------------------------------------------------------------------------
   // Stage 1 to stage 2: luma and the block averages. The line store data stays in
   // its read register until the next read, which only comes with a later input transfer.
   // ---------------------------------------------------------------------------------
   logic [SumWidth-1:0] tot_r, tot_g, tot_b;

   always_comb begin
      if (s1_ff.odd_row) begin
         tot_r = SumWidth'(s1_ff.pair_r) + ram_rdata[SumWidth-1:0];
         tot_g = SumWidth'(s1_ff.pair_g) + ram_rdata[2*SumWidth-1:SumWidth];
         tot_b = SumWidth'(s1_ff.pair_b) + ram_rdata[3*SumWidth-1:2*SumWidth];
      end else begin
         // Odd height: the last row's pair sums stand in for the missing row.
         tot_r = {s1_ff.pair_r, 1'b0};
         tot_g = {s1_ff.pair_g, 1'b0};
         tot_b = {s1_ff.pair_b, 1'b0};
      end
   end

   always_comb begin
      s2_in = s2_ff;
      if (s1_move) begin
         s2_in.x          = s1_ff.x;
         s2_in.y          = s1_ff.y;
         s2_in.luma       = luma_of(s1_ff.red, s1_ff.green, s1_ff.blue);
         s2_in.avg_r      = avg_of(tot_r);
         s2_in.avg_g      = avg_of(tot_g);
         s2_in.avg_b      = avg_of(tot_b);
         s2_in.mask       = s1_ff.mask;
         s2_in.frame_done = s1_ff.frame_done;
      end else if (take) begin
         s2_in.mask = rem;
      end
      if (s1_move) begin
         s2_v_in = 1'b1;
      end else if (take && single) begin
         s2_v_in = 1'b0;
      end else begin
         s2_v_in = s2_v_ff;
      end
   end

   // ---------------------------------------------------------------------------------
   // Emitter: the lowest pending result of stage 2 goes into the result register.
   // ---------------------------------------------------------------------------------
   logic           plane_ff, plane_in;
   coord_type      out_row_ff, out_row_in;
   coord_type      out_col_ff, out_col_in;
   pixel_byte_type val_ff, val_in;
   pixel_byte_type cr_ff, cr_in;
   logic           last_ff, last_in;
   logic           frame_end_ff, frame_end_in;

   always_comb begin
      plane_in     = plane_ff;
      out_row_in   = out_row_ff;
      out_col_in   = out_col_ff;
      val_in       = val_ff;
      cr_in        = cr_ff;
      last_in      = last_ff;
      frame_end_in = frame_end_ff;
      if (take) begin
         plane_in     = PlaneLuma;
         val_in       = s2_ff.luma;
         cr_in        = '0;
         last_in      = single;
         frame_end_in = single & s2_ff.frame_done;
         case (sel)
            MaskPadCol: begin
               out_row_in = s2_ff.y;
               out_col_in = s2_ff.x + CoordWidth'(1);
            end
            MaskPadRow: begin
               out_row_in = s2_ff.y + CoordWidth'(1);
               out_col_in = s2_ff.x;
            end
            MaskCorner: begin
               out_row_in = s2_ff.y + CoordWidth'(1);
               out_col_in = s2_ff.x + CoordWidth'(1);
            end
            MaskChroma: begin
               plane_in   = PlaneChroma;
               out_row_in = s2_ff.y >> 1;
               out_col_in = {s2_ff.x[CoordWidth-1:1], 1'b0};
               val_in     = cb_of(s2_ff.avg_r, s2_ff.avg_g, s2_ff.avg_b);
               cr_in      = cr_of(s2_ff.avg_r, s2_ff.avg_g, s2_ff.avg_b);
            end
            default: begin
               out_row_in = s2_ff.y;
               out_col_in = s2_ff.x;
            end
         endcase
      end
      if (take) begin
         rsp_v_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_v_in = 1'b0;
      end else begin
         rsp_v_in = rsp_v_ff;
      end
   end

   assign rsp.valid      = rsp_v_ff;
   assign rsp.plane      = plane_ff;
   assign rsp.out_row    = out_row_ff;
   assign rsp.out_col    = out_col_ff;
   assign rsp.luma_or_cb = val_ff;
   assign rsp.cr_value   = cr_ff;
   assign rsp.last       = last_ff;
   assign rsp.frame_end  = frame_end_ff;

   // ---------------------------------------------------------------------------------
   // Registers.
   // ---------------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff        <= WidthReset;
         height_ff       <= HeightReset;
         column_count_ff <= '0;
         row_count_ff    <= '0;
         hold_ff         <= '0;
         s1_v_ff         <= 1'b0;
         s2_v_ff         <= 1'b0;
         rsp_v_ff        <= 1'b0;
      end else begin
         width_ff        <= width_in;
         height_ff       <= height_in;
         column_count_ff <= column_count_in;
         row_count_ff    <= row_count_in;
         hold_ff         <= hold_in;
         s1_v_ff         <= s1_v_in;
         s2_v_ff         <= s2_v_in;
         rsp_v_ff        <= rsp_v_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff        <= s1_in;
      s2_ff        <= s2_in;
      plane_ff     <= plane_in;
      out_row_ff   <= out_row_in;
      out_col_ff   <= out_col_in;
      val_ff       <= val_in;
      cr_ff        <= cr_in;
      last_ff      <= last_in;
      frame_end_ff <= frame_end_in;
   end

   // ---------------------------------------------------------------------------------
   // Assertions.
   // ---------------------------------------------------------------------------------
   `R2N_ASSERT(a_s2_has_work, clock, reset, s2_v_ff |-> s2_ff.mask != '0)
   `R2N_ASSERT(a_frame_end_is_last, clock, reset, rsp_v_ff && frame_end_ff |-> last_ff)
   `R2N_ASSERT_ALWAYS(a_line_one_access, clock, !(ram_we && ram_re))
   `R2N_ASSERT(a_read_feeds_stage1, clock, reset, ram_re |=> s1_v_ff && s1_ff.odd_row)

endmodule
